// ===== rtl/lkos_pkg.sv =====
// Shared types, constants and helpers for the line keyword search block.
// Depends on nothing; imported by every module under rtl.
package lkos_pkg;

    localparam int MAX_KEYWORD_BYTES = 16;
    localparam int COUNT_BITS        = 24;

    localparam int KW_WORD_BITS  = 64;
    localparam int KW_WORD_BYTES = KW_WORD_BITS / 8;
    localparam int KW_BYTES      = 2 * KW_WORD_BYTES;
    localparam int KW_IDX_BITS   = $clog2(KW_BYTES);
    localparam int LEN_BITS      = 5;
    localparam int WANT_BITS     = 25;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]   LEN_LIMIT = LEN_BITS'(MAX_KEYWORD_BYTES);

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] UPPER_FIRST  = 8'h41;
    localparam logic [7:0] UPPER_LAST   = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_KW_LOW  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KW_HIGH = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KW_LEN  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CASE    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WANTED  = 3'd4;

    typedef enum logic [1:0] {
        EV_BYTE,
        EV_NEWLINE,
        EV_END
    } ev_kind_t;

    // Event handed from the window stage to the tally stage.
    typedef struct packed {
        logic     valid;
        ev_kind_t kind;
        logic     hit;
    } ev_t;

    // Map ASCII upper case to lower case when folding is enabled.
    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold_en);
        logic [7:0] r;
        r = b;
        if (fold_en && b >= UPPER_FIRST && b <= UPPER_LAST)
        begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ===== rtl/line_keyword_occurrence_search.sv =====
// Top level of the line keyword search: config registers, window cell chain
// and event stage. Depends on lkos_pkg, lkos_cell and lkos_tally.
//
// Usage:
//   Input channel (in_valid / in_stall, op, data_byte) carries one beat per
//   text byte (op = data) and one end beat (op = end) per buffer. Newline
//   bytes split lines; a line matches when the keyword lies inside it.
//   Output channel (out_valid / out_stall) carries one result beat per end
//   beat: found, match_line and total_matches of that buffer.
//   Configuration is a plain write port (wr_en, wr_index, wr_data); the user
//   must write it only while no buffer is in flight; the block does not enforce it.
// Throughput: one input beat per cycle while in_stall is low. Each byte shifts
//   the row of 16 window cells, which compare their new byte against the aligned
//   keyword byte on the way in; the cell hits then form the event's hit bit.
// Result path: an accepted end beat passes the event register, then the result
//   register, before its result beat shows on out_valid; a busy tally stage can
//   hold the end event in the event register (see Stall).
// Stall: the result register holds while out_stall is high; input beats keep
//   flowing until a second end beat reaches the tally stage, which then
//   raises in_stall until the waiting result is taken.
// Reset: rst_n clears all control state and loads the register defaults
//   (keyword length 0, case sensitive, first match wanted).
module line_keyword_occurrence_search (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic [7:0]                       data_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             found,
    output logic [lkos_pkg::COUNT_BITS-1:0]  match_line,
    output logic [lkos_pkg::COUNT_BITS-1:0]  total_matches,
    input  logic                             wr_en,
    input  logic [lkos_pkg::CFG_IDX_BITS-1:0] wr_index,
    input  logic [lkos_pkg::KW_WORD_BITS-1:0] wr_data
);
    import lkos_pkg::*;

    // Configuration registers.
    logic [KW_WORD_BITS-1:0] kw_low_reg;
    logic [KW_WORD_BITS-1:0] kw_high_reg;
    logic [LEN_BITS-1:0]     kw_len_reg;
    logic                    case_sens_reg;
    logic [WANT_BITS-1:0]    wanted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw_low_reg    <= '0;
            kw_high_reg   <= '0;
            kw_len_reg    <= '0;
            case_sens_reg <= 1'b1;
            wanted_reg    <= WANT_BITS'(1);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_KW_LOW:  kw_low_reg    <= wr_data;
                CFG_KW_HIGH: kw_high_reg   <= wr_data;
                CFG_KW_LEN:  kw_len_reg    <= wr_data[LEN_BITS-1:0];
                CFG_CASE:    case_sens_reg <= wr_data[0];
                CFG_WANTED:  wanted_reg    <= wr_data[WANT_BITS-1:0];
                default:     kw_len_reg    <= kw_len_reg;
            endcase
        end
    end

    // Input handshake and byte classification.
    logic accept;
    logic is_newline;
    logic shift;
    logic fold_en;
    logic tally_busy;

    assign in_stall   = tally_busy;
    assign accept     = in_valid && !in_stall;
    assign is_newline = (data_byte == NEWLINE_BYTE);
    assign shift      = accept && (op == OP_DATA) && !is_newline;
    assign fold_en    = !case_sens_reg;

    // Keyword as a byte array, byte 0 first.
    logic [KW_BYTES*8-1:0] kw_flat;
    logic [7:0]            kw_byte [KW_BYTES];

    assign kw_flat = {kw_high_reg, kw_low_reg};

    for (genvar k = 0; k < KW_BYTES; k++)
    begin : g_kw
        assign kw_byte[k] = kw_flat[k*8 +: 8];
    end

    // Row of window cells; cell 0 holds the newest byte of the line.
    // Cell i is matched against keyword byte (length - 1 - i).
    logic [7:0]                   win_byte [MAX_KEYWORD_BYTES];
    logic [MAX_KEYWORD_BYTES-1:0] cell_hit;
    logic [MAX_KEYWORD_BYTES-1:0] cell_ok;

    for (genvar i = 0; i < MAX_KEYWORD_BYTES; i++)
    begin : g_cell
        logic [LEN_BITS-1:0] key_sel;
        logic [7:0]          cell_in;

        assign key_sel = kw_len_reg - LEN_BITS'(1) - LEN_BITS'(i);

        if (i == 0)
        begin : g_head
            assign cell_in = data_byte;
        end
        else
        begin : g_link
            assign cell_in = win_byte[i-1];
        end

        lkos_cell u_cell (
            .clk      (clk),
            .shift    (shift),
            .fold_en  (fold_en),
            .byte_in  (cell_in),
            .key_byte (kw_byte[key_sel[KW_IDX_BITS-1:0]]),
            .byte_out (win_byte[i]),
            .hit      (cell_hit[i])
        );

        // Cells past the keyword length do not take part.
        assign cell_ok[i] = cell_hit[i] || (LEN_BITS'(i) >= kw_len_reg);
    end

    // Bytes seen in the current line, saturating at the window depth.
    logic [LEN_BITS-1:0] bil_reg, bil_next;

    always_comb
    begin
        bil_next = bil_reg;
        if (accept)
        begin
            if (op == OP_END || is_newline)
            begin
                bil_next = '0;
            end
            else if (bil_reg != LEN_LIMIT)
            begin
                bil_next = bil_reg + LEN_BITS'(1);
            end
        end
    end

    // Event register: the next event for the tally stage, held while it is busy.
    logic     ev_valid_reg, ev_valid_next;
    ev_kind_t ev_kind_reg, ev_kind_next;
    logic     len_ok;
    ev_t      ev;

    always_comb
    begin
        ev_valid_next = ev_valid_reg && tally_busy;
        ev_kind_next  = ev_kind_reg;
        if (accept)
        begin
            ev_valid_next = 1'b1;
            if (op == OP_END)
            begin
                ev_kind_next = EV_END;
            end
            else if (is_newline)
            begin
                ev_kind_next = EV_NEWLINE;
            end
            else
            begin
                ev_kind_next = EV_BYTE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bil_reg      <= '0;
            ev_valid_reg <= 1'b0;
            ev_kind_reg  <= EV_BYTE;
        end
        else
        begin
            bil_reg      <= bil_next;
            ev_valid_reg <= ev_valid_next;
            ev_kind_reg  <= ev_kind_next;
        end
    end

    // Whole-keyword hit: legal length, enough bytes in line, all cells agree.
    assign len_ok   = (kw_len_reg != '0) && (kw_len_reg <= LEN_LIMIT);
    assign ev.valid = ev_valid_reg;
    assign ev.kind  = ev_kind_reg;
    assign ev.hit   = len_ok && (bil_reg >= kw_len_reg) && (&cell_ok);

    lkos_tally u_tally (
        .clk           (clk),
        .rst_n         (rst_n),
        .ev            (ev),
        .wanted        (wanted_reg),
        .out_stall     (out_stall),
        .busy          (tally_busy),
        .out_valid     (out_valid),
        .found         (found),
        .match_line    (match_line),
        .total_matches (total_matches)
    );

endmodule

// ===== rtl/lkos_cell.sv =====
// One window cell: holds one text byte and its compare result.
// Depends on lkos_pkg.
module lkos_cell (
    input  logic       clk,
    input  logic       shift,
    input  logic       fold_en,
    input  logic [7:0] byte_in,
    input  logic [7:0] key_byte,
    output logic [7:0] byte_out,
    output logic       hit
);
    import lkos_pkg::*;

    logic [7:0] byte_reg;
    logic       hit_reg;
    logic       hit_next;

    assign hit_next = (fold_byte(byte_in, fold_en) == fold_byte(key_byte, fold_en));

    // Take the neighbor's byte and compare it on the way in.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
            hit_reg  <= hit_next;
        end
    end

    assign byte_out = byte_reg;
    assign hit      = hit_reg;

endmodule

// ===== rtl/lkos_tally.sv =====
// Tally stage: line and match counters, wanted-match record, result register.
// Depends on lkos_pkg.
module lkos_tally (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lkos_pkg::ev_t                 ev,
    input  logic [lkos_pkg::WANT_BITS-1:0] wanted,
    input  logic                          out_stall,
    output logic                          busy,
    output logic                          out_valid,
    output logic                          found,
    output logic [lkos_pkg::COUNT_BITS-1:0] match_line,
    output logic [lkos_pkg::COUNT_BITS-1:0] total_matches
);
    import lkos_pkg::*;

    logic                  line_matched_reg, line_matched_next;
    logic [COUNT_BITS-1:0] line_number_reg, line_number_next;
    logic [COUNT_BITS-1:0] match_count_reg, match_count_next;
    logic [COUNT_BITS-1:0] recorded_reg, recorded_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg;
    logic [COUNT_BITS-1:0] out_line_reg;
    logic [COUNT_BITS-1:0] out_total_reg;

    logic                  step;
    logic                  load_out;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  want_last;
    logic                  want_hit;

    assign busy      = ev.valid && (ev.kind == EV_END) && out_valid_reg && out_stall;
    assign step      = ev.valid && !busy;
    assign load_out  = step && (ev.kind == EV_END);
    assign count_inc = match_count_reg + COUNT_BITS'(1);
    assign want_last = wanted[WANT_BITS-1];
    assign want_hit  = !want_last && (wanted != '0)
                       && (count_inc == wanted[COUNT_BITS-1:0]);

    always_comb
    begin
        line_matched_next = line_matched_reg;
        line_number_next  = line_number_reg;
        match_count_next  = match_count_reg;
        recorded_next     = recorded_reg;
        if (step)
        begin
            case (ev.kind)
                EV_BYTE:
                begin
                    if (!line_matched_reg && ev.hit)
                    begin
                        line_matched_next = 1'b1;
                        if (match_count_reg != COUNT_MAX)
                        begin
                            match_count_next = count_inc;
                            if (want_last || want_hit)
                            begin
                                recorded_next = line_number_reg;
                            end
                        end
                    end
                end
                EV_NEWLINE:
                begin
                    line_matched_next = 1'b0;
                    if (line_number_reg != COUNT_MAX)
                    begin
                        line_number_next = line_number_reg + COUNT_BITS'(1);
                    end
                end
                EV_END:
                begin
                    line_matched_next = 1'b0;
                    line_number_next  = COUNT_BITS'(1);
                    match_count_next  = '0;
                    recorded_next     = '0;
                end
                default:
                begin
                    line_matched_next = line_matched_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_matched_reg <= 1'b0;
            line_number_reg  <= COUNT_BITS'(1);
            match_count_reg  <= '0;
            recorded_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            line_matched_reg <= line_matched_next;
            line_number_reg  <= line_number_next;
            match_count_reg  <= match_count_next;
            recorded_reg     <= recorded_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Result payload holds while stalled; load only on an end event.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_found_reg <= (recorded_reg != '0);
            out_line_reg  <= recorded_reg;
            out_total_reg <= match_count_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = out_found_reg;
    assign match_line    = out_line_reg;
    assign total_matches = out_total_reg;

endmodule

// ===== tb/line_keyword_occurrence_search_test.sv =====
// Self-checking testbench for line_keyword_occurrence_search: drives text
// buffers with random idling, predicts found/line/total per end beat and
// checks them in order. Depends on lkos_pkg and the block under rtl.
`timescale 1ns / 100ps

module line_keyword_occurrence_search_test;
    import lkos_pkg::*;

    localparam int MAX_GAP          = 12;
    localparam int SETTLE_CYCLES    = 4;
    localparam int DRAIN_LIMIT      = 2000;
    localparam int RANDOM_BEATS     = 1600;
    localparam int RANDOM_BUFFERS   = 60;

    // One report of a finished buffer, as the block presents it.
    typedef struct packed {
        logic                  found;
        logic [COUNT_BITS-1:0] line;
        logic [COUNT_BITS-1:0] total;
    } search_report_t;

    // Scoreboard: keeps its own copy of the registers and the search state,
    // updates them with every accepted input beat, turns each end beat into the
    // report it will cause, and compares the reports coming out against them in order.
    class line_match_scoreboard;
        logic [KW_WORD_BITS-1:0] kw_low;
        logic [KW_WORD_BITS-1:0] kw_high;
        logic [LEN_BITS-1:0]     kw_len;
        logic                    exact_case;
        int                      want_nth;

        logic [7:0]              recent [MAX_KEYWORD_BYTES];   // [0] is the newest byte
        int                      fill;
        logic                    line_hit;
        logic [COUNT_BITS-1:0]   line_no;
        logic [COUNT_BITS-1:0]   hits;
        logic [COUNT_BITS-1:0]   hit_line;

        search_report_t          reports_due [$];
        int unsigned             mismatches;

        function new();
            kw_low     = '0;
            kw_high    = '0;
            kw_len     = '0;
            exact_case = 1'b1;
            want_nth   = 1;
            mismatches = 0;
            clear_buffer();
        endfunction

        function void clear_buffer();
            foreach (recent[i])
                recent[i] = '0;
            fill     = 0;
            line_hit = 1'b0;
            line_no  = 1;
            hits     = '0;
            hit_line = '0;
        endfunction

        function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [KW_WORD_BITS-1:0] data);
            case (idx)
                CFG_KW_LOW:  kw_low     = data;
                CFG_KW_HIGH: kw_high    = data;
                CFG_KW_LEN:  kw_len     = data[LEN_BITS-1:0];
                CFG_CASE:    exact_case = data[0];
                CFG_WANTED:  want_nth   = int'($signed(data[WANT_BITS-1:0]));
                default:     ;
            endcase
        endfunction

        function logic [7:0] keyword_at(int k);
            if (k < KW_WORD_BYTES)
                return kw_low[k*8 +: 8];
            return kw_high[(k-KW_WORD_BYTES)*8 +: 8];
        endfunction

        function logic [7:0] fold_case(logic [7:0] b);
            if (!exact_case && b >= UPPER_FIRST && b <= UPPER_LAST)
                return b + CASE_OFFSET;
            return b;
        endfunction

        function logic window_holds_keyword();
            if (kw_len == 0 || kw_len > MAX_KEYWORD_BYTES || fill < kw_len)
                return 1'b0;
            for (int k = 0; k < kw_len; k++)
            begin
                if (fold_case(recent[kw_len-1-k]) != fold_case(keyword_at(k)))
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void take_beat(logic op_bit, logic [7:0] b);
            search_report_t rep;
            if (op_bit == OP_END)
            begin
                rep.found = (hit_line != 0);
                rep.line  = hit_line;
                rep.total = hits;
                reports_due.push_back(rep);
                clear_buffer();
            end
            else if (b == NEWLINE_BYTE)
            begin
                fill     = 0;
                line_hit = 1'b0;
                if (line_no != COUNT_MAX)
                    line_no++;
            end
            else
            begin
                for (int i = MAX_KEYWORD_BYTES - 1; i > 0; i--)
                    recent[i] = recent[i-1];
                recent[0] = b;
                if (fill < MAX_KEYWORD_BYTES)
                    fill++;
                if (!line_hit && window_holds_keyword())
                begin
                    line_hit = 1'b1;
                    if (hits != COUNT_MAX)
                    begin
                        hits++;
                        if (want_nth < 0)
                            hit_line = line_no;
                        else if (want_nth > 0 && int'(hits) == want_nth)
                            hit_line = line_no;
                    end
                end
            end
        endfunction

        function void check_report(logic f, logic [COUNT_BITS-1:0] l, logic [COUNT_BITS-1:0] t);
            search_report_t rep;
            if (reports_due.size() == 0)
            begin
                $display("%0t: unexpected result beat: found=%0d line=%0d total=%0d",
                         $time, f, l, t);
                mismatches++;
                return;
            end
            rep = reports_due.pop_front();
            if (f !== rep.found)
            begin
                $display("%0t: found: expected %0d, actual %0d", $time, rep.found, f);
                mismatches++;
            end
            if (l !== rep.line)
            begin
                $display("%0t: match_line: expected %0d, actual %0d", $time, rep.line, l);
                mismatches++;
            end
            if (t !== rep.total)
            begin
                $display("%0t: total_matches: expected %0d, actual %0d", $time, rep.total, t);
                mismatches++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic                    op        = OP_DATA;
    logic [7:0]              data_byte = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    found;
    logic [COUNT_BITS-1:0]   match_line;
    logic [COUNT_BITS-1:0]   total_matches;
    logic                    wr_en     = 1'b0;
    logic [CFG_IDX_BITS-1:0] wr_index  = '0;
    logic [KW_WORD_BITS-1:0] wr_data   = '0;

    line_match_scoreboard    sb;
    logic [7:0]              buffer_bytes [$];
    int unsigned             beats_sent;
    int unsigned             buffers_sent;
    logic                    in_quiet  = 1'b0;   // no gaps between input beats
    logic                    out_quiet = 1'b0;   // no stalls on the result side

    line_keyword_occurrence_search uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .match_line    (match_line),
        .total_matches (total_matches),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int draw_gap(logic quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Swap case on letters and on the bytes next to the letter ranges, so that
    // near misses such as '@' against '`' show up in the text.
    function automatic logic [7:0] swap_case(logic [7:0] b);
        logic [7:0] upper;
        upper = b & ~CASE_OFFSET;
        if (upper >= UPPER_FIRST - 8'd1 && upper <= UPPER_LAST + 8'd1)
            return b ^ CASE_OFFSET;
        return b;
    endfunction

    // Keyword bytes: mostly a tiny alphabet so random text hits often, some
    // bytes at the edges of the letter range, some fully random.
    function automatic logic [7:0] keyword_char();
        logic [7:0] b;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick <= 5)
            b = UPPER_FIRST + 8'($urandom_range(0, 2));
        else if (pick == 6)
            b = UPPER_FIRST - 8'd1;
        else if (pick == 7)
            b = ($urandom_range(0, 1) != 0) ? UPPER_LAST : UPPER_LAST + 8'd1;
        else
            b = 8'($urandom_range(0, 255));
        if (pick <= 7 && $urandom_range(0, 1) != 0)
            b = b + CASE_OFFSET;
        return b;
    endfunction

    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        if ($urandom_range(0, 9) < 7)
        begin
            b = sb.keyword_at($urandom_range(0, KW_BYTES - 1));
            if ($urandom_range(0, 1) != 0)
                b = swap_case(b);
        end
        else
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Present one beat after a random gap and hold it until the block takes it.
    // Leave in_valid high afterwards; a gap before the next beat or the settle pause drops it.
    task automatic send_beat(logic op_bit, logic [7:0] b);
        int gap;
        gap = draw_gap(in_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= op_bit;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // Write one register; the caller drops wr_en after its last write.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [KW_WORD_BITS-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        sb.set_register(idx, data);
    endtask

    task automatic apply_settings(logic [KW_WORD_BITS-1:0] lo, logic [KW_WORD_BITS-1:0] hi,
                                  logic [KW_WORD_BITS-1:0] len_word,
                                  logic [KW_WORD_BITS-1:0] case_word,
                                  logic [KW_WORD_BITS-1:0] want_word);
        write_reg(CFG_KW_LOW, lo);
        write_reg(CFG_KW_HIGH, hi);
        write_reg(CFG_KW_LEN, len_word);
        write_reg(CFG_CASE, case_word);
        write_reg(CFG_WANTED, want_word);
        wr_en <= 1'b0;
    endtask

    // Drop valid, wait for every outstanding report, then let the pipeline drain.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Draw a keyword setup; extremes of length and wanted occurrence come up
    // regularly, and the narrow registers sometimes carry junk in upper bits.
    task automatic pick_settings();
        logic [KW_WORD_BITS-1:0] lo;
        logic [KW_WORD_BITS-1:0] hi;
        logic [KW_WORD_BITS-1:0] junk;
        int                      len;
        int                      want;
        int                      pick;
        for (int k = 0; k < KW_WORD_BYTES; k++)
        begin
            lo[k*8 +: 8] = keyword_char();
            hi[k*8 +: 8] = keyword_char();
        end
        junk = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : '0;

        pick = $urandom_range(0, 19);
        if (pick == 0)
            len = 0;
        else if (pick == 1)
            len = MAX_KEYWORD_BYTES;
        else if (pick == 2)
            len = $urandom_range(MAX_KEYWORD_BYTES + 1, (1 << LEN_BITS) - 1);
        else if (pick <= 12)
            len = $urandom_range(1, 4);
        else
            len = $urandom_range(5, MAX_KEYWORD_BYTES);

        pick = $urandom_range(0, 19);
        if (pick <= 7)
            want = -1;
        else if (pick == 8)
            want = -int'($urandom_range(2, 1 << (WANT_BITS - 1)));
        else if (pick == 9)
            want = 0;
        else if (pick <= 17)
            want = $urandom_range(1, 4);
        else if (pick == 18)
            want = int'(COUNT_MAX);
        else
            want = $urandom_range(5, int'(COUNT_MAX));

        apply_settings(lo, hi,
                       {junk[KW_WORD_BITS-1:LEN_BITS], LEN_BITS'(len)},
                       {junk[KW_WORD_BITS-1:1], 1'($urandom_range(0, 1))},
                       {junk[KW_WORD_BITS-1:WANT_BITS], WANT_BITS'(want)});
    endtask

    // Build one buffer: lines made of filler runs, whole or cut keyword copies
    // (case swapped now and then), random bytes and stray newlines. The last
    // line goes without a newline half the time.
    task automatic compose_buffer();
        int         lines;
        int         segs;
        int         kind;
        int         cut;
        int         kw_bytes;
        logic       swap;
        logic [7:0] b;
        buffer_bytes.delete();
        kw_bytes = (sb.kw_len > MAX_KEYWORD_BYTES) ? MAX_KEYWORD_BYTES : int'(sb.kw_len);
        lines = $urandom_range(0, 6);
        for (int ln = 0; ln < lines; ln++)
        begin
            segs = $urandom_range(0, 4);
            for (int s = 0; s < segs; s++)
            begin
                kind = $urandom_range(0, 9);
                if (kind <= 3)
                begin
                    repeat ($urandom_range(1, 6)) buffer_bytes.push_back(filler_byte());
                end
                else if (kind <= 7)
                begin
                    cut  = (kind == 7) ? $urandom_range(0, kw_bytes) : kw_bytes;
                    swap = ($urandom_range(0, 1) != 0);
                    for (int k = 0; k < cut; k++)
                    begin
                        b = sb.keyword_at(k);
                        if (swap && $urandom_range(0, 1) != 0)
                            b = swap_case(b);
                        buffer_bytes.push_back(b);
                    end
                end
                else if (kind == 8)
                    buffer_bytes.push_back(8'($urandom_range(0, 255)));
                else
                    buffer_bytes.push_back(NEWLINE_BYTE);
            end
            if (ln < lines - 1 || $urandom_range(0, 1) != 0)
                buffer_bytes.push_back(NEWLINE_BYTE);
        end
    endtask

    // Send the text of a buffer, then its end beat with a junk data byte.
    task automatic send_buffer();
        foreach (buffer_bytes[i])
            send_beat(OP_DATA, buffer_bytes[i]);
        send_beat(OP_END, 8'($urandom_range(0, 255)));
        buffers_sent++;
    endtask

    // Watch both channels; feed accepted input beats to the predictor first,
    // then check any result beat taken on the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.take_beat(op, data_byte);
            if (out_valid && !out_stall)
                sb.check_report(found, match_line, total_matches);
        end
    end

    // Result side: stall for a random stretch, then take the next result beat.
    initial
    begin : result_sink
        int stall_run;
        forever
        begin
            stall_run = draw_gap(out_quiet);
            if (stall_run > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_run) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int waited;
        sb = new();
        beats_sent   = 0;
        buffers_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: keyword length 0 never matches. The end beat carries
        // a data byte that must be ignored.
        send_beat(OP_DATA, 8'h61);
        send_beat(OP_END, 8'hFF);
        settle();

        // Writes to indexes past the register list must be dropped.
        for (int k = int'(CFG_WANTED) + 1; k < (1 << CFG_IDX_BITS); k++)
            write_reg(CFG_IDX_BITS'(k), {$urandom, $urandom});

        // Keyword "aB" with junk in its unused bytes, case folded, last match
        // wanted through an all-ones write; the last line has no newline.
        apply_settings(64'h1234_5678_9ABC_4261, '1,
                       {{(KW_WORD_BITS-LEN_BITS){1'b1}}, LEN_BITS'(2)},
                       {{(KW_WORD_BITS-1){1'b1}}, 1'b0},
                       '1);
        send_beat(OP_DATA, 8'h61);
        send_beat(OP_DATA, 8'h62);
        send_beat(OP_DATA, NEWLINE_BYTE);
        send_beat(OP_DATA, 8'h41);
        send_beat(OP_DATA, 8'h42);
        send_beat(OP_END, 8'h00);
        settle();

        // Full 16-byte keyword holding 0x00, 0xFF and edge characters, exact
        // case, wanted occurrence at its maximum so it is never reached.
        apply_settings(64'h7B5B_605A_4041_FF00, 64'h7A61_4142_6162_4363,
                       KW_WORD_BITS'(MAX_KEYWORD_BYTES), KW_WORD_BITS'(1),
                       KW_WORD_BITS'(COUNT_MAX));
        for (int k = 0; k < KW_BYTES; k++)
            send_beat(OP_DATA, sb.keyword_at(k));
        send_beat(OP_END, 8'h5A);

        // Random phases: new settings while idle, then a few buffers.
        beats_sent   = 0;
        buffers_sent = 0;
        while (beats_sent < RANDOM_BEATS || buffers_sent < RANDOM_BUFFERS)
        begin
            settle();
            pick_settings();
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4))
            begin
                compose_buffer();
                send_buffer();
            end
        end

        // Drain with a bound, then give the pipeline its latency.
        in_valid <= 1'b0;
        waited = 0;
        while (sb.reports_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.reports_due.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            if (sb.reports_due.size() != 0)
                $display("%0t: %0d expected results never arrived", $time,
                         sb.reports_due.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
